// ===== hw/rtl/tsh_pkg.sv =====
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types and constants for the threshold histogram statistics block.
// ----------------------------------------------------------------------------
package tsh_pkg;

  localparam int NUM_THRESHOLDS_DEF = 16;
  localparam int DATA_W             = 64;
  localparam int OP_W               = 2;
  localparam int IDX_W              = 5;
  localparam int BANK_W             = 3;
  localparam int CFG_IDX_W          = 2;
  localparam int SMOOTH_SHIFT       = 6;
  localparam int SAMPLE_SHIFT       = 10;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [BANK_W-1:0] BANK_CUR = 3'd0;
  localparam logic [BANK_W-1:0] BANK_PER = 3'd1;
  localparam logic [BANK_W-1:0] BANK_TOT = 3'd2;
  localparam logic [BANK_W-1:0] BANK_SMO = 3'd3;
  localparam logic [BANK_W-1:0] BANK_AVG = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_AVERAGE = 2'd1;

  // One memory row holds one counter index across all four banks.
  typedef struct packed {
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] per;
    logic [DATA_W-1:0] tot;
    logic [DATA_W-1:0] smo;
  } row_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RES  = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/tsh_ram.sv =====
// ----------------------------------------------------------------------------
// tsh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tsh_div.sv =====
// ----------------------------------------------------------------------------
// tsh_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsh_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tsh_pkg::DATA_W-1:0] dividend,
  input  logic [tsh_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [tsh_pkg::DATA_W-1:0] quotient
);
  import tsh_pkg::*;

  localparam int CW = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_r, quo_r, dvs_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [DATA_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(DATA_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? DATA_W'(shifted - {1'b0, dvs_r}) : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/threshold_histogram_sample_stats.sv =====
// ----------------------------------------------------------------------------
// threshold_histogram_sample_stats
// Cumulative threshold histogram with period, total and smoothed banks.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; the input stalls until it is done.
// Counters live in one RAM row per counter index, and every row visit is a
// read step followed by a modify and write-back step. A push visits 2 +
// threshold_count rows; a tick visits all NUM_THRESHOLDS + 2 rows. A
// threshold write completes on acceptance, without leaving idle. A counter
// read visits its row, or returns zero when out of range. An average read
// visits the sum and count rows and then runs a bit-serial divider unless
// the count is zero, which returns the configured default average. No
// clearing pass is needed after reset: per-row valid bits make unwritten rows read as zero.
module threshold_histogram_sample_stats #(
  parameter int NUM_THRESHOLDS = tsh_pkg::NUM_THRESHOLDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tsh_pkg::OP_W-1:0]     in_operation,
  input  logic [tsh_pkg::DATA_W-1:0]   in_value,
  input  logic [tsh_pkg::IDX_W-1:0]    in_index,
  input  logic [tsh_pkg::BANK_W-1:0]   in_bank,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tsh_pkg::DATA_W-1:0]   out_read_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsh_pkg::DATA_W-1:0]   cfg_data
);
  import tsh_pkg::*;

  localparam int NCTR = NUM_THRESHOLDS + 2;
  localparam int AW   = $clog2(NCTR);
  localparam int TW   = (NUM_THRESHOLDS > 1) ? $clog2(NUM_THRESHOLDS) : 1;
  localparam int TCW  = $clog2(NUM_THRESHOLDS + 1);
  localparam int RW   = $bits(row_t);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       last_r, last_nxt;
  logic [OP_W-1:0]     op_r;
  logic [DATA_W-1:0]   val_r;
  logic [BANK_W-1:0]   bank_r;
  logic [DATA_W-1:0]   sum_r;
  logic [DATA_W-1:0]   cnt_r;
  logic                neg_r;
  logic [DATA_W-1:0]   res_r, res_nxt;
  logic [TCW-1:0]      tc_r;
  logic [DATA_W-1:0]   dflt_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [NCTR-1:0]     row_vld_r;
  logic [NUM_THRESHOLDS-1:0] thr_vld_r;

  logic                accept;
  logic                in_range;
  logic                out_free;
  logic                ram_we;
  row_t                row_q, row_eff, row_new;
  logic [RW-1:0]       row_rdata;
  logic                thr_we;
  logic [TW-1:0]       thr_raddr;
  logic [DATA_W-1:0]   thr_q, thr_eff;
  logic                bin_hit;
  logic [DATA_W-1:0]   smo_sum;
  logic                div_start, div_done;
  logic [DATA_W-1:0]   div_a, div_d, div_q;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_range = (int'(in_index) < NCTR) &&
                    ((int'(in_index) < 2) || (int'(in_index) - 2 < int'(tc_r)));

  // Threshold table.
  assign thr_we    = accept && (in_operation == OP_WRITE) &&
                     (int'(in_index) < NUM_THRESHOLDS);
  assign thr_raddr = TW'(ptr_r - AW'(2));

  tsh_ram #(.WIDTH(DATA_W), .DEPTH(NUM_THRESHOLDS), .AW(TW)) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (TW'(in_index)),
    .wdata (in_value),
    .raddr (thr_raddr),
    .rdata (thr_q)
  );

  // Counter rows.
  assign ram_we = (state_r == ST_MOD) && ((op_r == OP_PUSH) || (op_r == OP_TICK));

  tsh_ram #(.WIDTH(RW), .DEPTH(NCTR), .AW(AW)) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (row_new),
    .raddr (ptr_r),
    .rdata (row_rdata)
  );

  assign row_q   = row_t'(row_rdata);
  assign row_eff = row_vld_r[ptr_r] ? row_q : '0;
  assign thr_eff = (ptr_r >= AW'(2) && thr_vld_r[thr_raddr]) ? thr_q : '0;
  assign bin_hit = $signed(val_r) >= $signed(thr_eff);
  assign smo_sum = (row_eff.smo << SMOOTH_SHIFT) - row_eff.smo +
                   (row_eff.cur << SAMPLE_SHIFT);

  always_comb begin
    row_new = row_eff;
    if (op_r == OP_PUSH) begin
      if (ptr_r == AW'(0)) begin
        row_new.cur = row_eff.cur + val_r;
      end else if (ptr_r == AW'(1)) begin
        row_new.cur = row_eff.cur + DATA_W'(1);
      end else begin
        row_new.cur = row_eff.cur + DATA_W'(bin_hit);
      end
    end else begin
      row_new.cur = '0;
      row_new.per = row_eff.cur;
      row_new.tot = row_eff.tot + row_eff.cur;
      row_new.smo = {{SMOOTH_SHIFT{smo_sum[DATA_W-1]}}, smo_sum[DATA_W-1:SMOOTH_SHIFT]};
    end
  end

  // Average divider works on magnitudes; the sign is restored afterward.
  assign div_a = sum_r[DATA_W-1] ? DATA_W'(-sum_r) : sum_r;
  assign div_d = row_eff.cur[DATA_W-1] ? DATA_W'(-row_eff.cur) : row_eff.cur;

  tsh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ptr_nxt = '0;
          case (in_operation)
            OP_PUSH: begin
              last_nxt  = AW'(tc_r) + AW'(1);
              state_nxt = ST_RD;
            end
            OP_TICK: begin
              last_nxt  = AW'(NCTR - 1);
              state_nxt = ST_RD;
            end
            OP_READ: begin
              if (in_bank == BANK_AVG) begin
                state_nxt = ST_RD;
              end else if (in_bank < BANK_AVG && in_range) begin
                ptr_nxt   = AW'(in_index);
                state_nxt = ST_RD;
              end else begin
                res_nxt   = '0;
                state_nxt = ST_RES;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD: state_nxt = ST_MOD;
      ST_MOD: begin
        if (op_r == OP_READ) begin
          if (bank_r != BANK_AVG) begin
            case (bank_r)
              BANK_CUR: res_nxt = row_eff.cur;
              BANK_PER: res_nxt = row_eff.per;
              BANK_TOT: res_nxt = row_eff.tot;
              default:  res_nxt = row_eff.smo;
            endcase
            state_nxt = ST_RES;
          end else if (ptr_r == AW'(0)) begin
            ptr_nxt   = AW'(1);
            state_nxt = ST_RD;
          end else if (row_eff.cur == '0) begin
            res_nxt   = dflt_r;
            state_nxt = ST_RES;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else if (ptr_r == last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = neg_r ? DATA_W'(-div_q) : div_q;
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tc_r        <= '0;
      dflt_r      <= '0;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      thr_vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESHOLD_COUNT) begin
          tc_r <= (int'(cfg_data[IDX_W-1:0]) > NUM_THRESHOLDS) ?
                  TCW'(NUM_THRESHOLDS) : TCW'(cfg_data[IDX_W-1:0]);
        end else if (cfg_index == CFG_DEFAULT_AVERAGE) begin
          dflt_r <= cfg_data;
        end
      end
      if (ram_we) begin
        row_vld_r[ptr_r] <= 1'b1;
      end
      if (thr_we) begin
        thr_vld_r[TW'(in_index)] <= 1'b1;
      end
      if (state_r == ST_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
    if (accept) begin
      op_r   <= in_operation;
      val_r  <= in_value;
      bank_r <= in_bank;
    end
    if (state_r == ST_MOD && op_r == OP_READ && ptr_r == AW'(0)) begin
      sum_r <= row_eff.cur;
    end
    if (div_start) begin
      cnt_r <= row_eff.cur;
      neg_r <= sum_r[DATA_W-1] ^ row_eff.cur[DATA_W-1];
    end
    if (state_r == ST_RES && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

  // The divider only runs for a nonzero count.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (cnt_r != '0))
    else $error("divider started with zero count");

  a_we_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_MOD))
    else $error("row write outside modify step");

  a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RES))
    else $error("result presented without a finished read");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");

endmodule
